// ===== src/input_movie_event_stream_decoder_core_defines.svh =====
// Assertion macros for the event stream decoder core.
`ifndef INPUT_MOVIE_EVENT_STREAM_DECODER_CORE_DEFINES_SVH
`define INPUT_MOVIE_EVENT_STREAM_DECODER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define IMESD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMESD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/imesd_pkg.sv =====
// Shared types and constants for the event stream decoder.
`timescale 1ns / 1ps
package imesd_pkg;

  localparam int WORD_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int CMD_W       = 2;
  localparam int ERR_W       = 4;
  localparam int OUT_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    PH_EVENT,
    PH_DELTA,
    PH_EXT
  } phase_t;

  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POWER = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE         = 4'd0;
  localparam logic [ERR_W-1:0] ERR_TRUNC_DELTA  = 4'd1;
  localparam logic [ERR_W-1:0] ERR_TRUNC_EXT    = 4'd2;
  localparam logic [ERR_W-1:0] ERR_BEYOND_LEN   = 4'd3;
  localparam logic [ERR_W-1:0] ERR_BAD_CMD      = 4'd4;
  localparam logic [ERR_W-1:0] ERR_CMD_NO_FRAME = 4'd5;
  localparam logic [ERR_W-1:0] ERR_TWO_CMDS     = 4'd6;
  localparam logic [ERR_W-1:0] ERR_PAD_NO_FRAME = 4'd7;

  typedef struct packed {
    logic [WORD_W-1:0] run_length;
    logic [WORD_W-1:0] run_pads;
    logic [WORD_W-1:0] frame_index;
    logic [CMD_W-1:0]  command;
    logic [ERR_W-1:0]  error;
    logic              four_players;
    logic              last;
  } out_rec_t;

endpackage

// ===== src/imesd_in_if.sv =====
// Input channel: one stream byte per transaction.
`timescale 1ns / 1ps
interface imesd_in_if;
  logic                          valid;
  logic                          ready;
  logic [imesd_pkg::BYTE_W-1:0]  stream_byte;
  logic                          final_byte;

  modport source (output valid, output stream_byte, output final_byte, input ready);
  modport sink   (input valid, input stream_byte, input final_byte, output ready);
endinterface

// ===== src/imesd_out_if.sv =====
// Result channel: one run record per transaction.
`timescale 1ns / 1ps
interface imesd_out_if;
  logic                          valid;
  logic                          ready;
  logic [imesd_pkg::WORD_W-1:0]  run_length;
  logic [imesd_pkg::WORD_W-1:0]  run_pads;
  logic [imesd_pkg::WORD_W-1:0]  frame_index;
  logic [imesd_pkg::CMD_W-1:0]   command;
  logic [imesd_pkg::ERR_W-1:0]   error;
  logic                          four_players;
  logic                          last;

  modport source (output valid, output run_length, output run_pads, output frame_index,
                  output command, output error, output four_players, output last,
                  input ready);
  modport sink   (input valid, input run_length, input run_pads, input frame_index,
                  input command, input error, input four_players, input last,
                  output ready);
endinterface

// ===== src/input_movie_event_stream_decoder_core.sv =====
// Event stream decoder core: byte parser, event state and result queue.
//
// Usage:
//   in_ch  (valid/ready): one stream byte per transaction, final_byte on the
//          last byte of a stream.
//   out_ch (valid/ready): run records; a final byte that completes an event
//          gives two records, the second one the fill run with last set.
//   cfg_we/cfg_wdata: declared frame count, written while the block is idle.
// Timing:
//   An accepted byte is decoded while it sits in the input register and its
//   records enter the result queue at the edge on which that register drains,
//   so a record reaches out_ch through the input register and the result queue.
//   One byte per cycle sustained; the input register drains only while the
//   result queue (OUT_DEPTH entries) has room for two records.
// Reset (rst_n low, synchronous): parser state, queue and declared frame
//   count are cleared.
// Stall: when out_ch.ready is low the queue fills and in_ch.ready drops once
//   fewer than two entries are free; nothing is lost.
`timescale 1ns / 1ps
`include "input_movie_event_stream_decoder_core_defines.svh"
module input_movie_event_stream_decoder_core #(
  parameter int OUT_DEPTH = imesd_pkg::OUT_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  imesd_in_if.sink                      in_ch,
  imesd_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [imesd_pkg::WORD_W-1:0]  cfg_wdata
);
  import imesd_pkg::*;

  localparam int PW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int CW = $clog2(OUT_DEPTH + 1);

  // configuration
  logic [WORD_W-1:0] decl_r;

  // input register
  logic              stg_valid_r;
  logic [BYTE_W-1:0] stg_byte_r;
  logic              stg_fin_r;
  logic              stg_go;

  // decoder state
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] held_r, held_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [1:0]        left_r, left_nxt;
  logic [WORD_W-1:0] cur_r, cur_nxt;
  logic [WORD_W-1:0] pads_r, pads_nxt;
  logic              four_r, four_nxt;
  logic              chere_r, chere_nxt;
  logic [ERR_W-1:0]  sticky_r, sticky_nxt;

  // result queue
  out_rec_t          fifo_r [OUT_DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r, wr_ptr_p1;
  logic [CW-1:0]     count_r;
  logic              pop;
  logic [1:0]        n_push;
  out_rec_t          rec0, rec1;

  assign stg_go      = stg_valid_r && (count_r <= CW'(OUT_DEPTH - 2));
  assign in_ch.ready = !stg_valid_r || stg_go;
  assign pop         = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decl_r      <= '0;
      stg_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        decl_r <= cfg_wdata;
      end
      if (in_ch.ready) begin
        stg_valid_r <= in_ch.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_byte_r <= in_ch.stream_byte;
      stg_fin_r  <= in_ch.final_byte;
    end
  end

  // decode
  always_comb begin
    logic [1:0]        n;
    logic [1:0]        pos;
    logic [WORD_W-1:0] shifted;
    logic [WORD_W-1:0] acc_new;
    logic [1:0]        left_new;
    logic              ev_go;
    logic [BYTE_W-1:0] ev;
    logic [WORD_W-1:0] delta;
    logic [WORD_W:0]   nf;
    logic              fl_go;
    logic [ERR_W-1:0]  fl_code;
    logic [WORD_W-1:0] fl_frame;
    logic              ok;
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] pads_prev;
    logic [WORD_W-1:0] fill;
    logic              restart;

    phase_nxt  = phase_r;
    held_nxt   = held_r;
    acc_nxt    = acc_r;
    left_nxt   = left_r;
    cur_nxt    = cur_r;
    pads_nxt   = pads_r;
    four_nxt   = four_r;
    chere_nxt  = chere_r;
    sticky_nxt = sticky_r;
    n_push     = 2'd0;
    rec0       = '0;
    rec1       = '0;

    n         = held_r[6:5];
    pos       = n - left_r;
    shifted   = '0;
    acc_new   = acc_r;
    left_new  = left_r;
    ev_go     = 1'b0;
    ev        = held_r;
    delta     = '0;
    nf        = '0;
    fl_go     = 1'b0;
    fl_code   = ERR_NONE;
    fl_frame  = cur_r;
    ok        = 1'b0;
    cmd       = CMD_NONE;
    pads_prev = pads_r;
    fill      = '0;
    restart   = 1'b0;

    if (stg_go) begin
      if (sticky_r != ERR_NONE) begin
        if (stg_fin_r) begin
          n_push            = 2'd1;
          rec0.run_pads     = pads_r;
          rec0.frame_index  = cur_r;
          rec0.command      = CMD_NONE;
          rec0.error        = sticky_r;
          rec0.four_players = four_r;
          rec0.last         = 1'b1;
          restart           = 1'b1;
        end
      end else begin
        case (phase_r)
          PH_DELTA: begin
            case (pos)
              2'd0:    shifted = {24'd0, stg_byte_r};
              2'd1:    shifted = {16'd0, stg_byte_r, 8'd0};
              default: shifted = {8'd0, stg_byte_r, 16'd0};
            endcase
            acc_new  = acc_r | shifted;
            left_new = (left_r != 2'd0) ? left_r - 2'd1 : 2'd0;
            if (left_new != 2'd0) begin
              if (stg_fin_r) begin
                fl_go   = 1'b1;
                fl_code = ERR_TRUNC_DELTA;
              end else begin
                acc_nxt  = acc_new;
                left_nxt = left_new;
              end
            end else if ((n == 2'd1 || n == 2'd2) && acc_new == '0) begin
              if (stg_fin_r) begin
                fl_go   = 1'b1;
                fl_code = ERR_TRUNC_EXT;
              end else begin
                phase_nxt = PH_EXT;
                acc_nxt   = acc_new;
                left_nxt  = 2'd0;
              end
            end else begin
              ev_go = 1'b1;
              delta = acc_new;
            end
          end
          PH_EXT: begin
            ev_go = 1'b1;
            delta = (n == 2'd2) ? {8'd0, stg_byte_r, 16'd0} : {16'd0, stg_byte_r, 8'd0};
          end
          default: begin
            held_nxt = stg_byte_r;
            if (stg_byte_r[6:5] == 2'd0) begin
              ev_go = 1'b1;
              ev    = stg_byte_r;
              delta = '0;
            end else if (stg_fin_r) begin
              fl_go   = 1'b1;
              fl_code = ERR_TRUNC_DELTA;
            end else begin
              left_nxt  = stg_byte_r[6:5];
              acc_nxt   = '0;
              phase_nxt = PH_DELTA;
            end
          end
        endcase

        if (ev_go) begin
          nf        = {1'b0, cur_r} + {1'b0, delta};
          phase_nxt = PH_EVENT;
          acc_nxt   = '0;
          left_nxt  = 2'd0;
          if (nf > {1'b0, decl_r}) begin
            fl_go    = 1'b1;
            fl_code  = ERR_BEYOND_LEN;
            fl_frame = cur_r;
          end else if (ev[7]) begin
            fl_frame = nf[WORD_W-1:0];
            if (ev[4:0] > 5'(CMD_POWER)) begin
              fl_go   = 1'b1;
              fl_code = ERR_BAD_CMD;
            end else if (ev[4:0] != 5'd0 && nf >= {1'b0, decl_r}) begin
              fl_go   = 1'b1;
              fl_code = ERR_CMD_NO_FRAME;
            end else if (ev[4:0] != 5'd0 && delta == '0 && chere_r) begin
              fl_go   = 1'b1;
              fl_code = ERR_TWO_CMDS;
            end else begin
              ok = 1'b1;
              if (delta != '0) begin
                chere_nxt = 1'b0;
              end
              if (ev[4:0] != 5'd0) begin
                chere_nxt = 1'b1;
              end
              cmd = ev[CMD_W-1:0];
            end
          end else begin
            fl_frame = nf[WORD_W-1:0];
            if (nf >= {1'b0, decl_r}) begin
              fl_go   = 1'b1;
              fl_code = ERR_PAD_NO_FRAME;
            end else begin
              ok = 1'b1;
              if (delta != '0) begin
                chere_nxt = 1'b0;
              end
              pads_nxt = pads_r ^ (WORD_W'(1) << {ev[4:3], ev[2:0]});
              if (ev[4]) begin
                four_nxt = 1'b1;
              end
            end
          end
        end

        if (ok) begin
          cur_nxt           = nf[WORD_W-1:0];
          n_push            = 2'd1;
          rec0.run_length   = delta;
          rec0.run_pads     = pads_prev;
          rec0.frame_index  = nf[WORD_W-1:0];
          rec0.command      = cmd;
          rec0.error        = ERR_NONE;
          rec0.four_players = four_nxt;
          rec0.last         = 1'b0;
          if (stg_fin_r) begin
            fill              = (decl_r > nf[WORD_W-1:0]) ? decl_r - nf[WORD_W-1:0] : '0;
            n_push            = 2'd2;
            rec1.run_length   = fill;
            rec1.run_pads     = pads_nxt;
            rec1.frame_index  = nf[WORD_W-1:0] + fill;
            rec1.command      = CMD_NONE;
            rec1.error        = ERR_NONE;
            rec1.four_players = four_nxt;
            rec1.last         = 1'b1;
            restart           = 1'b1;
          end
        end

        if (fl_go) begin
          sticky_nxt        = fl_code;
          n_push            = 2'd1;
          rec0.run_length   = '0;
          rec0.run_pads     = pads_r;
          rec0.frame_index  = fl_frame;
          rec0.command      = CMD_NONE;
          rec0.error        = fl_code;
          rec0.four_players = four_r;
          rec0.last         = stg_fin_r;
          restart           = stg_fin_r;
        end
      end
    end

    if (restart) begin
      phase_nxt  = PH_EVENT;
      held_nxt   = '0;
      acc_nxt    = '0;
      left_nxt   = 2'd0;
      cur_nxt    = '0;
      pads_nxt   = '0;
      four_nxt   = 1'b0;
      chere_nxt  = 1'b0;
      sticky_nxt = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_EVENT;
      held_r   <= '0;
      acc_r    <= '0;
      left_r   <= 2'd0;
      cur_r    <= '0;
      pads_r   <= '0;
      four_r   <= 1'b0;
      chere_r  <= 1'b0;
      sticky_r <= ERR_NONE;
    end else begin
      phase_r  <= phase_nxt;
      held_r   <= held_nxt;
      acc_r    <= acc_nxt;
      left_r   <= left_nxt;
      cur_r    <= cur_nxt;
      pads_r   <= pads_nxt;
      four_r   <= four_nxt;
      chere_r  <= chere_nxt;
      sticky_r <= sticky_nxt;
    end
  end

  // result queue
  assign wr_ptr_p1 = (wr_ptr_r == PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo_r[wr_ptr_r] <= rec0;
    end
    if (n_push == 2'd2) begin
      fifo_r[wr_ptr_p1] <= rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      case (n_push)
        2'd1:    wr_ptr_r <= wr_ptr_p1;
        2'd2:    wr_ptr_r <= (wr_ptr_p1 == PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_p1 + PW'(1);
        default: wr_ptr_r <= wr_ptr_r;
      endcase
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      count_r <= count_r + CW'(n_push) - CW'(pop);
    end
  end

  assign out_ch.valid        = (count_r != '0);
  assign out_ch.run_length   = fifo_r[rd_ptr_r].run_length;
  assign out_ch.run_pads     = fifo_r[rd_ptr_r].run_pads;
  assign out_ch.frame_index  = fifo_r[rd_ptr_r].frame_index;
  assign out_ch.command      = fifo_r[rd_ptr_r].command;
  assign out_ch.error        = fifo_r[rd_ptr_r].error;
  assign out_ch.four_players = fifo_r[rd_ptr_r].four_players;
  assign out_ch.last         = fifo_r[rd_ptr_r].last;

  `IMESD_ASSERT_NOW(a_queue_bound, 1'b1, count_r <= CW'(OUT_DEPTH), "result queue overflow")
  `IMESD_ASSERT_NOW(a_room_for_two, stg_go, count_r <= CW'(OUT_DEPTH - 2), "decode without room")
  `IMESD_ASSERT_NOW(a_sticky_silent, stg_go && sticky_r != ERR_NONE && !stg_fin_r,
                    n_push == 2'd0, "record emitted while error is sticky")
  `IMESD_ASSERT_NEXT(a_final_restarts, stg_go && stg_fin_r,
                     phase_r == PH_EVENT && sticky_r == ERR_NONE && cur_r == '0,
                     "state not cleared after final byte")

endmodule

// ===== bench/input_movie_event_stream_decoder_core_tb.sv =====
// Self-checking testbench for the event stream decoder core: random byte streams vs. a scoreboard.
`timescale 1ns / 1ps
module input_movie_event_stream_decoder_core_tb;
  import imesd_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int ITEM_TARGET   = 800;
  localparam int REPORT_CAP    = 200;

  class run_tracker;
    logic [31:0] frames_decl;
    phase_t      ph;
    logic [7:0]  ev_hold;
    logic [31:0] acc;
    logic [1:0]  left;
    logic [31:0] cur;
    logic [31:0] pads;
    logic        four;
    logic        cmd_here;
    logic [3:0]  sticky;
    out_rec_t    runs_due[$];
    int          errors;

    function new();
      frames_decl = '0;
      errors = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      ph = PH_EVENT;
      ev_hold = '0;
      acc = '0;
      left = '0;
      cur = '0;
      pads = '0;
      four = 1'b0;
      cmd_here = 1'b0;
      sticky = ERR_NONE;
    endfunction

    function void queue_run(logic [31:0] len, logic [31:0] pd, logic [31:0] frm,
                            logic [1:0] cmd, logic [3:0] err, logic lst);
      out_rec_t r;
      r.run_length = len;
      r.run_pads = pd;
      r.frame_index = frm;
      r.command = cmd;
      r.error = err;
      r.four_players = four;
      r.last = lst;
      runs_due.push_back(r);
    endfunction

    function void abort(logic [3:0] code, logic [31:0] frm, logic fin);
      sticky = code;
      queue_run(32'd0, pads, frm, CMD_NONE, code, fin);
      if (fin) clear_stream();
    endfunction

    function void apply_event(logic [31:0] delta, logic fin);
      logic [32:0] nf;
      logic [31:0] prior;
      logic [4:0]  c;
      logic [1:0]  plr;
      logic [31:0] fill;
      nf = {1'b0, cur} + {1'b0, delta};
      prior = pads;
      c = '0;
      ph = PH_EVENT;
      acc = '0;
      left = '0;
      if (nf > {1'b0, frames_decl}) begin
        abort(ERR_BEYOND_LEN, cur, fin);
        return;
      end
      if (ev_hold[7]) begin
        c = ev_hold[4:0];
        if (c > 2) begin
          abort(ERR_BAD_CMD, nf[31:0], fin);
          return;
        end
        if (c != 0 && nf >= {1'b0, frames_decl}) begin
          abort(ERR_CMD_NO_FRAME, nf[31:0], fin);
          return;
        end
        if (c != 0 && delta == 0 && cmd_here) begin
          abort(ERR_TWO_CMDS, nf[31:0], fin);
          return;
        end
        if (delta != 0) cmd_here = 1'b0;
        if (c != 0) cmd_here = 1'b1;
      end else begin
        plr = ev_hold[4:3];
        if (nf >= {1'b0, frames_decl}) begin
          abort(ERR_PAD_NO_FRAME, nf[31:0], fin);
          return;
        end
        if (delta != 0) cmd_here = 1'b0;
        pads = pads ^ (32'd1 << {plr, ev_hold[2:0]});
        if (plr >= 2) four = 1'b1;
      end
      cur = nf[31:0];
      queue_run(delta, prior, cur, c[1:0], ERR_NONE, 1'b0);
      if (fin) begin
        fill = (frames_decl > cur) ? frames_decl - cur : 32'd0;
        queue_run(fill, pads, cur + fill, CMD_NONE, ERR_NONE, 1'b1);
        clear_stream();
      end
    endfunction

    function void decode_byte(logic [7:0] b, logic fin);
      logic [1:0] n;
      logic [1:0] pos;
      n = ev_hold[6:5];
      if (sticky != ERR_NONE) begin
        if (fin) begin
          queue_run(32'd0, pads, cur, CMD_NONE, sticky, 1'b1);
          clear_stream();
        end
        return;
      end
      if (ph == PH_DELTA) begin
        pos = n - left;
        acc = acc | ({24'd0, b} << (8 * ((pos > 2) ? 2 : pos)));
        left = (left != 2'd0) ? left - 2'd1 : 2'd0;
        if (left != 0) begin
          if (fin) abort(ERR_TRUNC_DELTA, cur, fin);
          return;
        end
        if ((n == 1 || n == 2) && acc == 0) begin
          if (fin) abort(ERR_TRUNC_EXT, cur, fin);
          else ph = PH_EXT;
          return;
        end
        apply_event(acc, fin);
        return;
      end
      if (ph == PH_EXT) begin
        apply_event({24'd0, b} << ((n == 2) ? 16 : 8), fin);
        return;
      end
      ev_hold = b;
      n = b[6:5];
      if (n == 0) begin
        apply_event(32'd0, fin);
        return;
      end
      if (fin) begin
        abort(ERR_TRUNC_DELTA, cur, fin);
        return;
      end
      left = n;
      acc = '0;
      ph = PH_DELTA;
    endfunction

    function void match_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        if (errors < REPORT_CAP)
          $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_record(out_rec_t got);
      out_rec_t want;
      if (runs_due.size() == 0) begin
        if (errors < REPORT_CAP)
          $display("%0t ns: unexpected record, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = runs_due.pop_front();
      match_field("run_length", want.run_length, got.run_length);
      match_field("run_pads", want.run_pads, got.run_pads);
      match_field("frame_index", want.frame_index, got.frame_index);
      match_field("command", want.command, got.command);
      match_field("error", want.error, got.error);
      match_field("four_players", want.four_players, got.four_players);
      match_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  bit          no_idle = 1'b0;
  bit          long_hold = 1'b0;
  int          items = 0;
  int          cycles = 0;
  run_tracker  runs;

  imesd_in_if  in_if();
  imesd_out_if out_if();

  input_movie_event_stream_decoder_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.stream_byte <= b;
    in_if.final_byte <= fin;
    do @(posedge clk); while (!in_if.ready);
    items++;
    runs.decode_byte(b, fin);
  endtask

  // sender idles until every expected record is back
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (runs.runs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frames(input logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    runs.frames_decl = v;
  endtask

  function automatic logic [7:0] low_delta();
    logic [7:0] v;
    if ($urandom_range(0, 3) == 0) v = $urandom;
    else v = $urandom_range(0, 4);
    return v;
  endfunction

  function automatic logic [7:0] high_delta();
    logic [7:0] v;
    if ($urandom_range(0, 3) == 0) v = $urandom;
    else v = 8'd0;
    return v;
  endfunction

  task automatic play_stream(input int n_events);
    logic [7:0] seq[$];
    logic [4:0] c;
    logic [1:0] nb;
    int         r;
    int         cut;
    for (int e = 0; e < n_events; e++) begin
      r = $urandom_range(0, 9);
      nb = (r < 5) ? 2'd0 : (r < 8) ? 2'd1 : (r == 8) ? 2'd2 : 2'd3;
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 15) == 0) c = $urandom_range(3, 31);
        else c = $urandom_range(0, 2);
        seq.push_back({1'b1, nb, c});
      end else begin
        c = $urandom_range(0, 31);
        seq.push_back({1'b0, nb, c});
      end
      if (nb == 1) seq.push_back(low_delta());
      if (nb >= 2) begin
        seq.push_back(low_delta());
        seq.push_back(high_delta());
      end
      if (nb == 3) seq.push_back(high_delta());
      if ((nb == 1 && seq[$] == 0) || (nb == 2 && seq[$] == 0 && seq[$-1] == 0))
        seq.push_back(high_delta());
    end
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, seq.size());
      while (seq.size() > cut) void'(seq.pop_back());
    end
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
  endtask

  task automatic play_noise();
    int         len;
    logic [7:0] b;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      b = $urandom;
      send_byte(b, (i == len - 1) || ($urandom_range(0, 5) == 0));
    end
  endtask

  initial begin
    out_rec_t got;
    int       gap;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got.run_length = out_if.run_length;
      got.run_pads = out_if.run_pads;
      got.frame_index = out_if.frame_index;
      got.command = out_if.command;
      got.error = out_if.error;
      got.four_players = out_if.four_players;
      got.last = out_if.last;
      runs.check_record(got);
    end
  end

  initial begin
    int          phase_no;
    int          stream_no;
    bit          hold_done;
    logic [31:0] fv;
    runs = new();
    in_if.valid = 1'b0;
    in_if.stream_byte = '0;
    in_if.final_byte = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // frame count still zero: command with no frame left
    send_byte(8'h81, 1'b1);
    settle();
    set_frames(32'd100);
    // pad event, reset after delta, second command at same frame, ignored byte
    send_byte(8'h00, 1'b0); send_byte(8'hA1, 1'b0); send_byte(8'h05, 1'b0);
    send_byte(8'h82, 1'b0); send_byte(8'h13, 1'b0); send_byte(8'h00, 1'b1);
    // extended deltas of one and two bytes, player 3, then bad command
    send_byte(8'h3F, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'hFF, 1'b1);
    // three-byte delta, power on the last byte with fill run
    send_byte(8'hE0, 1'b0); send_byte(8'h10, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h82, 1'b1);
    // truncated delta, truncated extension, past declared length
    send_byte(8'h20, 1'b1);
    send_byte(8'h20, 1'b0); send_byte(8'h00, 1'b1);
    send_byte(8'h20, 1'b0); send_byte(8'hFF, 1'b1);

    phase_no = 0;
    stream_no = 0;
    hold_done = 1'b0;
    while (items < ITEM_TARGET) begin
      if (stream_no % 6 == 0) begin
        settle();
        case (phase_no % 8)
          0: fv = 32'hFFFF_FFFF;
          1: fv = 32'd0;
          2: fv = 32'd1;
          3: fv = 32'd40;
          4: fv = 32'd300;
          5: fv = 32'd70000;
          6: fv = $urandom_range(5, 2000);
          default: fv = $urandom;
        endcase
        set_frames(fv);
        no_idle = ($urandom_range(0, 3) == 0);
        phase_no++;
      end
      stream_no++;
      if (!hold_done && items > ITEM_TARGET / 2) begin
        hold_done = 1'b1;
        settle();
        set_frames(32'hFFFF_FFFF);
        no_idle = 1'b1;
        long_hold = 1'b1;
        play_stream(40);
        settle();
        no_idle = 1'b0;
      end else if ($urandom_range(0, 6) == 0) begin
        play_noise();
      end else begin
        play_stream($urandom_range(1, 12));
      end
    end
    settle();
    if (runs.errors == 0 && runs.runs_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
